// ----- rtl/assert_macros.svh -----
// Assertion macros used by the RTL top level.
// No dependencies; assertions compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Expression must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- rtl/lwc_pkg.sv -----
// Shared types, constants and helpers for the LCD window command generator.
// No dependencies.
package lwc_pkg;

    // Configuration register indexes
    localparam logic REG_SCREEN_W = 1'b0;
    localparam logic REG_SCREEN_H = 1'b1;

    localparam logic [12:0] SCREEN_W_RST = 13'd480;
    localparam logic [12:0] SCREEN_H_RST = 13'd320;
    localparam logic [12:0] SCREEN_MAX   = 13'd4096;

    // Controller command bytes
    localparam logic [7:0] CMD_CASET = 8'h2A;
    localparam logic [7:0] CMD_RASET = 8'h2B;
    localparam logic [7:0] CMD_RAMWR = 8'h2C;
    localparam logic [7:0] PARAM_PAD = 8'h00;

    // Positions of the command words in the sequence
    localparam logic [4:0] IDX_CASET = 5'd0;
    localparam logic [4:0] IDX_RASET = 5'd9;
    localparam logic [4:0] IDX_RAMWR = 5'd18;

    // Queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // One classified request
    typedef struct packed {
        logic        rej;
        logic [15:0] x0;
        logic [15:0] y0;
        logic [15:0] x1;
        logic [15:0] y1;
        logic [24:0] pcount;
    } entry_t;

    // Front pipeline occupancy
    typedef struct packed {
        logic s1_valid;
        logic s2_valid;
        logic s3_valid;
    } front_stat_t;

    // Screen sizes above the maximum count as the maximum
    function automatic logic [12:0] sat_screen(input logic [12:0] v);
        return (v > SCREEN_MAX) ? SCREEN_MAX : v;
    endfunction

endpackage

// ----- rtl/lwc_front.sv -----
// Front end: three-stage pipeline that clips or checks a rectangle and
// builds the window bounds and pixel count. Depends on lwc_pkg.
module lwc_front
    import lwc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               action,
    input  logic signed [15:0] rect_x,
    input  logic signed [15:0] rect_y,
    input  logic signed [15:0] rect_w,
    input  logic signed [15:0] rect_h,
    input  logic [12:0]        screen_width,
    input  logic [12:0]        screen_height,
    output logic               out_valid,
    output entry_t             out_entry,
    output front_stat_t        stat
);

    // Stage 1 registers: left/top clipping
    logic               s1_valid_reg;
    logic               s1_blit_reg;
    logic               s1_bad_reg;
    logic [14:0]        s1_x_reg;
    logic [14:0]        s1_y_reg;
    logic signed [16:0] s1_w_reg;
    logic signed [16:0] s1_h_reg;

    // Stage 2 registers: right/bottom clipping and decision
    logic        s2_valid_reg;
    logic        s2_ok_reg;
    logic [14:0] s2_x_reg;
    logic [14:0] s2_y_reg;
    logic [12:0] s2_w_reg;
    logic [12:0] s2_h_reg;

    // Stage 3 registers: finished entry
    logic   s3_valid_reg;
    entry_t s3_entry_reg;

    // Stage 1 combinational
    logic               neg_x;
    logic               neg_y;
    logic [14:0]        x_next;
    logic [14:0]        y_next;
    logic signed [16:0] w_next;
    logic signed [16:0] h_next;
    logic               bad_next;

    always_comb
    begin
        neg_x    = rect_x[15];
        neg_y    = rect_y[15];
        x_next   = neg_x ? 15'd0 : rect_x[14:0];
        y_next   = neg_y ? 15'd0 : rect_y[14:0];
        w_next   = neg_x ? (17'(rect_w) + 17'(rect_x)) : 17'(rect_w);
        h_next   = neg_y ? (17'(rect_h) + 17'(rect_y)) : 17'(rect_h);
        bad_next = neg_x || neg_y || rect_w[15] || (rect_w == 16'sd0)
                   || rect_h[15] || (rect_h == 16'sd0);
    end

    // Stage 2 combinational
    logic [12:0]        sw;
    logic [12:0]        sh;
    logic signed [17:0] sum_x;
    logic signed [17:0] sum_y;
    logic signed [17:0] rem_x;
    logic signed [17:0] rem_y;
    logic               over_x;
    logic               over_y;
    logic signed [17:0] wf;
    logic signed [17:0] hf;
    logic               pos_w;
    logic               pos_h;
    logic               ok_next;

    always_comb
    begin
        sw     = sat_screen(screen_width);
        sh     = sat_screen(screen_height);
        sum_x  = $signed({3'b000, s1_x_reg}) + 18'(s1_w_reg);
        sum_y  = $signed({3'b000, s1_y_reg}) + 18'(s1_h_reg);
        over_x = sum_x > $signed({5'b00000, sw});
        over_y = sum_y > $signed({5'b00000, sh});
        rem_x  = $signed({5'b00000, sw}) - $signed({3'b000, s1_x_reg});
        rem_y  = $signed({5'b00000, sh}) - $signed({3'b000, s1_y_reg});
        wf     = over_x ? rem_x : 18'(s1_w_reg);
        hf     = over_y ? rem_y : 18'(s1_h_reg);
        pos_w  = !wf[17] && (wf != 18'sd0);
        pos_h  = !hf[17] && (hf != 18'sd0);
        if (s1_blit_reg)
            ok_next = !s1_bad_reg && !over_x && !over_y;
        else
            ok_next = pos_w && pos_h;
    end

    // Stage 3 combinational: end corners and pixel count
    entry_t      entry_next;
    logic [25:0] product;

    always_comb
    begin
        product           = {13'd0, s2_w_reg} * {13'd0, s2_h_reg};
        entry_next.rej    = !s2_ok_reg;
        entry_next.x0     = {1'b0, s2_x_reg};
        entry_next.y0     = {1'b0, s2_y_reg};
        entry_next.x1     = {1'b0, s2_x_reg} + {3'b000, s2_w_reg} - 16'd1;
        entry_next.y1     = {1'b0, s2_y_reg} + {3'b000, s2_h_reg} - 16'd1;
        entry_next.pcount = product[24:0];
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // Payload pipeline
    always_ff @(posedge clk)
    begin
        s1_blit_reg  <= action;
        s1_bad_reg   <= bad_next;
        s1_x_reg     <= x_next;
        s1_y_reg     <= y_next;
        s1_w_reg     <= w_next;
        s1_h_reg     <= h_next;
        s2_ok_reg    <= ok_next;
        s2_x_reg     <= s1_x_reg;
        s2_y_reg     <= s1_y_reg;
        s2_w_reg     <= wf[12:0];
        s2_h_reg     <= hf[12:0];
        s3_entry_reg <= entry_next;
    end

    assign out_valid     = s3_valid_reg;
    assign out_entry     = s3_entry_reg;
    assign stat.s1_valid = s1_valid_reg;
    assign stat.s2_valid = s2_valid_reg;
    assign stat.s3_valid = s3_valid_reg;

endmodule

// ----- rtl/lwc_fifo.sv -----
// Short queue of classified requests between front and back.
// Depends on lwc_pkg.
module lwc_fifo
    import lwc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  entry_t             push_entry,
    input  logic               pop,
    output entry_t             head,
    output logic               not_empty,
    output logic [FIFO_CW-1:0] count
);

    entry_t               slot_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg;
    logic [FIFO_AW-1:0]   rd_ptr_reg;
    logic [FIFO_CW-1:0]   count_reg;

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            if (push && !pop)
                count_reg <= count_reg + FIFO_CW'(1);
            else if (pop && !push)
                count_reg <= count_reg - FIFO_CW'(1);
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

    assign head      = slot_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign count     = count_reg;

endmodule

// ----- rtl/lwc_back.sv -----
// Back end: sequencer that turns one queued request into its word stream.
// Depends on lwc_pkg.
module lwc_back
    import lwc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_not_empty,
    input  entry_t      q_head,
    output logic        q_pop,
    output logic        strobe,
    output logic        is_data,
    output logic [7:0]  out_byte,
    output logic        status,
    output logic [24:0] pixel_count,
    output logic        last
);

    typedef enum logic {ST_IDLE, ST_EMIT} state_t;

    state_t      state_reg,    state_next;
    logic [4:0]  idx_reg,      idx_next;
    entry_t      ent_reg,      ent_next;
    logic        strobe_reg,   strobe_next;
    logic        is_data_reg,  is_data_next;
    logic [7:0]  byte_reg,     byte_next;
    logic        status_reg,   status_next;
    logic [24:0] pcount_reg,   pcount_next;
    logic        last_reg,     last_next;

    logic        finishing;
    logic [2:0]  p;
    logic        is_y;
    logic [15:0] bound;

    // Parameter word selection for the current position
    always_comb
    begin
        is_y  = idx_reg > IDX_RASET;
        p     = is_y ? 3'(idx_reg - IDX_RASET - 5'd1) : 3'(idx_reg - 5'd1);
        if (is_y)
            bound = p[2] ? ent_reg.y1 : ent_reg.y0;
        else
            bound = p[2] ? ent_reg.x1 : ent_reg.x0;
    end

    // Next state and output words
    always_comb
    begin
        finishing    = (state_reg == ST_EMIT) && (ent_reg.rej || idx_reg == IDX_RAMWR);
        q_pop        = q_not_empty && ((state_reg == ST_IDLE) || finishing);
        state_next   = state_reg;
        idx_next     = idx_reg;
        ent_next     = ent_reg;
        strobe_next  = 1'b0;
        is_data_next = 1'b0;
        byte_next    = PARAM_PAD;
        status_next  = 1'b0;
        pcount_next  = '0;
        last_next    = 1'b0;

        if (state_reg == ST_EMIT)
        begin
            strobe_next = 1'b1;
            if (ent_reg.rej)
            begin
                status_next = 1'b1;
                last_next   = 1'b1;
            end
            else if (idx_reg == IDX_CASET)
                byte_next = CMD_CASET;
            else if (idx_reg == IDX_RASET)
                byte_next = CMD_RASET;
            else if (idx_reg == IDX_RAMWR)
            begin
                byte_next   = CMD_RAMWR;
                pcount_next = ent_reg.pcount;
                last_next   = 1'b1;
            end
            else
            begin
                is_data_next = 1'b1;
                if (!p[0])
                    byte_next = PARAM_PAD;
                else if (p[1])
                    byte_next = bound[7:0];
                else
                    byte_next = bound[15:8];
            end
            idx_next = idx_reg + 5'd1;
        end

        // Load the next request, or go idle after the last word
        if (q_pop)
        begin
            state_next = ST_EMIT;
            idx_next   = IDX_CASET;
            ent_next   = q_head;
        end
        else if (finishing)
            state_next = ST_IDLE;
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            ent_reg     <= '0;
            strobe_reg  <= 1'b0;
            is_data_reg <= 1'b0;
            byte_reg    <= '0;
            status_reg  <= 1'b0;
            pcount_reg  <= '0;
            last_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            ent_reg     <= ent_next;
            strobe_reg  <= strobe_next;
            is_data_reg <= is_data_next;
            byte_reg    <= byte_next;
            status_reg  <= status_next;
            pcount_reg  <= pcount_next;
            last_reg    <= last_next;
        end
    end

    assign strobe      = strobe_reg;
    assign is_data     = is_data_reg;
    assign out_byte    = byte_reg;
    assign status      = status_reg;
    assign pixel_count = pcount_reg;
    assign last        = last_reg;

endmodule

// ----- rtl/lcd_window_command_generator.sv -----
// Top level: APB screen-size registers, front pipeline, queue and back sequencer.
// Depends on lwc_pkg, lwc_front, lwc_fifo, lwc_back and assert_macros.svh.
//
// Usage:
//   A request (action, rect_x, rect_y, rect_w, rect_h) is taken at a rising
//   edge where start is high and busy is low. Fill requests (action 0) are
//   clipped to the screen; blit requests (action 1) must lie wholly on it.
//   An accepted window produces 19 words: 0x2A, x0/x1 parameters, 0x2B,
//   y0/y1 parameters, 0x2C; the last word carries pixel_count. A dropped or
//   rejected request produces one word with status and last set.
//   Each word is on the output ports for one cycle with strobe high; the
//   receiver cannot stall, so words leave at one per cycle.
//   A request passes the three front stages, the queue, the sequencer's request
//   register and its word register. The rate is set by the back sequencer
//   emitting one word per cycle. The 3-stage front and a 4-entry queue let
//   several requests be taken while a window drains; busy rises when front
//   plus queue hold 4 requests. screen_width (address 0) and screen_height
//   (address 4) are written over APB; the user must write them only while idle,
//   which the block does not enforce. Reset loads 480 x 320, empties the queue.
`include "assert_macros.svh"

module lcd_window_command_generator
    import lwc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Request channel
    input  logic        start,
    output logic        busy,
    input  logic        action,
    input  logic [15:0] rect_x,
    input  logic [15:0] rect_y,
    input  logic [15:0] rect_w,
    input  logic [15:0] rect_h,
    // Result channel
    output logic        strobe,
    output logic        is_data,
    output logic [7:0]  out_byte,
    output logic        status,
    output logic [24:0] pixel_count,
    output logic        last,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [12:0] screen_w_reg;
    logic [12:0] screen_h_reg;
    logic        cfg_wr;
    logic        accept;

    front_stat_t        fstat;
    logic               front_valid;
    entry_t             front_entry;
    entry_t             q_head;
    logic               q_not_empty;
    logic               q_pop;
    logic [FIFO_CW-1:0] q_count;
    logic [FIFO_CW-1:0] in_flight;

    // Configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_w_reg <= SCREEN_W_RST;
            screen_h_reg <= SCREEN_H_RST;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_SCREEN_W)
                screen_w_reg <= pwdata[12:0];
            else
                screen_h_reg <= pwdata[12:0];
        end
    end

    assign prdata = (paddr[2] == REG_SCREEN_H) ? {19'd0, screen_h_reg}
                                                : {19'd0, screen_w_reg};

    // Credit check: never take more than the queue can absorb
    assign in_flight = q_count + FIFO_CW'(fstat.s1_valid) + FIFO_CW'(fstat.s2_valid)
                       + FIFO_CW'(fstat.s3_valid);
    assign busy      = in_flight >= FIFO_CW'(FIFO_DEPTH);
    assign accept    = start && !busy;

    lwc_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (accept),
        .action        (action),
        .rect_x        (rect_x),
        .rect_y        (rect_y),
        .rect_w        (rect_w),
        .rect_h        (rect_h),
        .screen_width  (screen_w_reg),
        .screen_height (screen_h_reg),
        .out_valid     (front_valid),
        .out_entry     (front_entry),
        .stat          (fstat)
    );

    lwc_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (front_valid),
        .push_entry (front_entry),
        .pop        (q_pop),
        .head       (q_head),
        .not_empty  (q_not_empty),
        .count      (q_count)
    );

    lwc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .strobe      (strobe),
        .is_data     (is_data),
        .out_byte    (out_byte),
        .status      (status),
        .pixel_count (pixel_count),
        .last        (last)
    );

    // Checks
    `ASSERT_IMPLIES(a_no_overflow, clk, rst_n, front_valid, (q_count < FIFO_CW'(FIFO_DEPTH)) || q_pop, "queue overflow")
    `ASSERT_ALWAYS(a_credit, clk, rst_n, in_flight <= FIFO_CW'(FIFO_DEPTH), "too many requests in flight")
    `ASSERT_IMPLIES(a_reject_last, clk, rst_n, strobe && status, last && !is_data && (pixel_count == 25'd0), "reject word malformed")
    `ASSERT_IMPLIES(a_last_ramwr, clk, rst_n, strobe && last && !status, !is_data && (out_byte == CMD_RAMWR), "window not closed by memory write")

endmodule
